/* rtl/core/int4_vector_distance_accumulator_defines.svh */
// Assertion macros for the RTL of the int4 vector distance accumulator.
// Both macros assume the enclosing module has clk_i and rst_ni.
`ifndef INT4_VECTOR_DISTANCE_ACCUMULATOR_DEFINES_SVH
`define INT4_VECTOR_DISTANCE_ACCUMULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define IVDA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ivda: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IVDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ivda: next-cycle check failed");

`else

`define IVDA_ASSERT_SAME(label, ante, cons)
`define IVDA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/ivda_pkg.sv */
`timescale 1ns / 1ps

package ivda_pkg;

  localparam int unsigned WordW             = 64;
  localparam int unsigned NibbleW           = 4;
  localparam int unsigned NibblesPerWordDef = 16;
  localparam int unsigned ModeW             = 2;

  localparam int unsigned PrimaryW = 29;
  localparam int unsigned NormW    = 27;

  // Largest single-element contributions: (-8 - 7)^2 and (-8)^2.
  localparam int unsigned MaxSqDiff = 225;
  localparam int unsigned MaxSq     = 64;

  localparam logic signed [PrimaryW-1:0] PrimaryMax = {1'b0, {(PrimaryW-1){1'b1}}};
  localparam logic signed [PrimaryW-1:0] PrimaryMin = {1'b1, {(PrimaryW-1){1'b0}}};
  localparam logic [NormW-1:0]           NormMax    = {NormW{1'b1}};

  typedef enum logic [ModeW-1:0] {
    MODE_INNER_PRODUCT = 2'd0,
    MODE_SQ_L2         = 2'd1,
    MODE_IP_NORMS      = 2'd2
  } metric_mode_e;

  typedef struct packed {
    logic [WordW-1:0] left_word;
    logic [WordW-1:0] right_word;
    logic             last_word;
  } in_item_t;

  typedef struct packed {
    logic signed [PrimaryW-1:0] primary_sum;
    logic [NormW-1:0]           left_energy;
    logic [NormW-1:0]           right_energy;
    logic                       saturated;
  } result_t;

  typedef struct packed {
    logic         valid;
    logic         last;
    metric_mode_e mode;
  } stage_ctl_t;

  // Signed width of one word's primary sum (sign bit included).
  function automatic int unsigned prim_word_w(int unsigned nibbles);
    return $clog2(nibbles * MaxSqDiff + 1) + 1;
  endfunction

  // Unsigned width of one word's norm sum.
  function automatic int unsigned norm_word_w(int unsigned nibbles);
    return $clog2(nibbles * MaxSq + 1);
  endfunction

endpackage

/* rtl/core/ivda_stream_if.sv */
`timescale 1ns / 1ps

interface ivda_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

/* rtl/core/ivda_word_sum.sv */
`timescale 1ns / 1ps

module ivda_word_sum
  import ivda_pkg::*;
#(
  parameter int unsigned NIBBLES_PER_WORD = NibblesPerWordDef
) (
  input  logic [WordW-1:0]                                left_word_i,
  input  logic [WordW-1:0]                                right_word_i,
  input  metric_mode_e                                    mode_i,
  output logic signed [prim_word_w(NIBBLES_PER_WORD)-1:0] prim_word_o,
  output logic [norm_word_w(NIBBLES_PER_WORD)-1:0]        left_sq_word_o,
  output logic [norm_word_w(NIBBLES_PER_WORD)-1:0]        right_sq_word_o
);

  localparam int unsigned PrimWordW = prim_word_w(NIBBLES_PER_WORD);
  localparam int unsigned NormWordW = norm_word_w(NIBBLES_PER_WORD);
  localparam int unsigned TreeDepth = $clog2(NIBBLES_PER_WORD);
  localparam int unsigned Leaves    = 1 << TreeDepth;
  localparam int unsigned Nodes     = 2 * Leaves - 1;

  logic signed [PrimWordW-1:0] prim_node  [Nodes];
  logic [NormWordW-1:0]        left_node  [Nodes];
  logic [NormWordW-1:0]        right_node [Nodes];
  logic                        sq_sel;

  assign sq_sel = (mode_i == MODE_SQ_L2);

  // One lane per nibble; leaves beyond the nibble count contribute zero.
  for (genvar i = 0; i < Leaves; i++) begin : g_lane
    if (i < NIBBLES_PER_WORD) begin : g_used
      logic signed [NibbleW-1:0] a;
      logic signed [NibbleW-1:0] b;
      logic signed [NibbleW:0]   d;
      logic signed [7:0]         ip;
      logic [7:0]                sq;
      logic [6:0]                aa;
      logic [6:0]                bb;

      // (n xor 8) - 8 is the two's complement reading of the nibble.
      assign a  = left_word_i[NibbleW*i +: NibbleW];
      assign b  = right_word_i[NibbleW*i +: NibbleW];
      assign d  = a - b;
      assign ip = a * b;
      assign sq = d * d;
      assign aa = a * a;
      assign bb = b * b;

      assign prim_node[Leaves-1+i]  = sq_sel ? PrimWordW'($signed({1'b0, sq}))
                                             : PrimWordW'(ip);
      assign left_node[Leaves-1+i]  = NormWordW'(aa);
      assign right_node[Leaves-1+i] = NormWordW'(bb);
    end else begin : g_pad
      assign prim_node[Leaves-1+i]  = '0;
      assign left_node[Leaves-1+i]  = '0;
      assign right_node[Leaves-1+i] = '0;
    end
  end

  // Binary adder tree, heap ordered: node k sums nodes 2k+1 and 2k+2.
  for (genvar k = 0; k < Leaves - 1; k++) begin : g_tree
    assign prim_node[k]  = prim_node[2*k+1] + prim_node[2*k+2];
    assign left_node[k]  = left_node[2*k+1] + left_node[2*k+2];
    assign right_node[k] = right_node[2*k+1] + right_node[2*k+2];
  end

  assign prim_word_o     = prim_node[0];
  assign left_sq_word_o  = left_node[0];
  assign right_sq_word_o = right_node[0];

endmodule

/* rtl/core/ivda_accum.sv */
`timescale 1ns / 1ps
`include "int4_vector_distance_accumulator_defines.svh"

module ivda_accum
  import ivda_pkg::*;
#(
  parameter int unsigned NIBBLES_PER_WORD = NibblesPerWordDef
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  stage_ctl_t                                      ctl_i,
  input  logic signed [prim_word_w(NIBBLES_PER_WORD)-1:0] prim_word_i,
  input  logic [norm_word_w(NIBBLES_PER_WORD)-1:0]        left_sq_word_i,
  input  logic [norm_word_w(NIBBLES_PER_WORD)-1:0]        right_sq_word_i,
  input  logic                                            out_ready_i,
  output logic                                            out_valid_o,
  output result_t                                         result_o,
  output logic                                            advance_o
);

  localparam int unsigned PrimWordW = prim_word_w(NIBBLES_PER_WORD);
  localparam int unsigned NormWordW = norm_word_w(NIBBLES_PER_WORD);

  stage_ctl_t                  s2_q;
  logic signed [PrimWordW-1:0] prim_q;
  logic [NormWordW-1:0]        left_q;
  logic [NormWordW-1:0]        right_q;

  logic signed [PrimaryW-1:0] prim_acc_q, prim_acc_d;
  logic [NormW-1:0]           left_acc_q, left_acc_d;
  logic [NormW-1:0]           right_acc_q, right_acc_d;
  logic                       sat_q, sat_d;
  logic                       out_valid_q, out_valid_d;
  result_t                    result_q, result_d;

  logic signed [PrimaryW:0]   prim_sum;
  logic [NormW:0]             left_total;
  logic [NormW:0]             right_total;
  logic                       prim_clamp, left_clamp, right_clamp;
  logic signed [PrimaryW-1:0] prim_new;
  logic [NormW-1:0]           left_new, right_new;
  logic                       sat_new;
  logic                       is_norms;
  logic                       advance;
  logic                       fire;

  // The whole pipeline moves unless a finished result is stuck in the output register.
  assign advance = !out_valid_q || out_ready_i;
  assign fire    = s2_q.valid && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '{valid: 1'b0, last: 1'b0, mode: MODE_INNER_PRODUCT};
    end else if (advance) begin
      s2_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ctl_i.valid) begin
      prim_q  <= prim_word_i;
      left_q  <= left_sq_word_i;
      right_q <= right_sq_word_i;
    end
  end

  always_comb begin
    is_norms    = (s2_q.mode == MODE_IP_NORMS);
    prim_sum    = (PrimaryW + 1)'(prim_acc_q) + (PrimaryW + 1)'(prim_q);
    left_total  = (NormW + 1)'(left_acc_q) + (NormW + 1)'(left_q);
    right_total = (NormW + 1)'(right_acc_q) + (NormW + 1)'(right_q);

    // A sum outside the primary range shows as differing top two bits.
    prim_clamp  = prim_sum[PrimaryW] != prim_sum[PrimaryW-1];
    left_clamp  = left_total[NormW];
    right_clamp = right_total[NormW];

    if (prim_clamp) begin
      prim_new = prim_sum[PrimaryW] ? PrimaryMin : PrimaryMax;
    end else begin
      prim_new = prim_sum[PrimaryW-1:0];
    end
    left_new  = left_clamp ? NormMax : left_total[NormW-1:0];
    right_new = right_clamp ? NormMax : right_total[NormW-1:0];
    sat_new   = sat_q || prim_clamp || (is_norms && (left_clamp || right_clamp));
  end

  always_comb begin
    prim_acc_d  = prim_acc_q;
    left_acc_d  = left_acc_q;
    right_acc_d = right_acc_q;
    sat_d       = sat_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (fire) begin
      if (s2_q.last) begin
        result_d = '{primary_sum:  prim_new,
                     left_energy:  is_norms ? left_new : '0,
                     right_energy: is_norms ? right_new : '0,
                     saturated:    sat_new};
        out_valid_d = 1'b1;
        prim_acc_d  = '0;
        left_acc_d  = '0;
        right_acc_d = '0;
        sat_d       = 1'b0;
      end else begin
        prim_acc_d = prim_new;
        sat_d      = sat_new;
        if (is_norms) begin
          left_acc_d  = left_new;
          right_acc_d = right_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_acc_q  <= '0;
      left_acc_q  <= '0;
      right_acc_q <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prim_acc_q  <= prim_acc_d;
      left_acc_q  <= left_acc_d;
      right_acc_q <= right_acc_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign advance_o   = advance;

  `IVDA_ASSERT_NEXT(a_clear_after_result, fire && s2_q.last, prim_acc_q == '0 && left_acc_q == '0 && right_acc_q == '0 && !sat_q)
  `IVDA_ASSERT_NEXT(a_norms_zero_outside_mode, fire && s2_q.last && s2_q.mode != MODE_IP_NORMS, result_q.left_energy == '0 && result_q.right_energy == '0)
  `IVDA_ASSERT_NEXT(a_hold_on_stall, out_valid_q && !out_ready_i, $stable(prim_acc_q) && $stable(left_acc_q) && $stable(sat_q))
  `IVDA_ASSERT_NEXT(a_clamp_sets_flag, fire && !s2_q.last && prim_clamp, sat_q)

endmodule

/* rtl/core/int4_vector_distance_accumulator.sv */
// After its last item, a result passes the input, stage-2 and output registers, in that order.
// Throughput: one item per cycle; the accumulate-and-clamp loop is not pipelined.
// A result waiting in the output register stalls the pipeline and the input.
// Reset (rst_ni low, asynchronous) clears the accumulators, the saturation flag,
// the pipeline valids and sets the mode register to inner product.
`timescale 1ns / 1ps

module int4_vector_distance_accumulator
  import ivda_pkg::*;
#(
  parameter int unsigned NIBBLES_PER_WORD = NibblesPerWordDef
) (
  input logic           clk_i,
  input logic           rst_ni,
  ivda_stream_if.sink   cfg_i,
  ivda_stream_if.sink   item_i,
  ivda_stream_if.source result_o
);

  localparam int unsigned PrimWordW = prim_word_w(NIBBLES_PER_WORD);
  localparam int unsigned NormWordW = norm_word_w(NIBBLES_PER_WORD);

  metric_mode_e                mode_q;
  stage_ctl_t                  s1_ctl_q, s1_ctl_d;
  logic [WordW-1:0]            left_q;
  logic [WordW-1:0]            right_q;
  logic signed [PrimWordW-1:0] prim_word;
  logic [NormWordW-1:0]        left_sq_word;
  logic [NormWordW-1:0]        right_sq_word;
  logic                        advance;
  logic                        out_valid;
  result_t                     result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INNER_PRODUCT;
    end else if (cfg_i.valid) begin
      mode_q <= metric_mode_e'(cfg_i.payload);
    end
  end

  assign item_i.ready = advance;

  // Each item carries the mode that was current when it was taken.
  assign s1_ctl_d = '{valid: item_i.valid, last: item_i.payload.last_word, mode: mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '{valid: 1'b0, last: 1'b0, mode: MODE_INNER_PRODUCT};
    end else if (advance) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_i.valid) begin
      left_q  <= item_i.payload.left_word;
      right_q <= item_i.payload.right_word;
    end
  end

  ivda_word_sum #(
    .NIBBLES_PER_WORD(NIBBLES_PER_WORD)
  ) u_word_sum (
    .left_word_i    (left_q),
    .right_word_i   (right_q),
    .mode_i         (s1_ctl_q.mode),
    .prim_word_o    (prim_word),
    .left_sq_word_o (left_sq_word),
    .right_sq_word_o(right_sq_word)
  );

  ivda_accum #(
    .NIBBLES_PER_WORD(NIBBLES_PER_WORD)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (s1_ctl_q),
    .prim_word_i    (prim_word),
    .left_sq_word_i (left_sq_word),
    .right_sq_word_i(right_sq_word),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (out_valid),
    .result_o       (result),
    .advance_o      (advance)
  );

  assign result_o.valid   = out_valid;
  assign result_o.payload = result;

endmodule
